>>> sv/sha256_stream_hasher_core_defines.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, types and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;

	typedef logic [31:0] word_t;

	// One queued block word: from the front end to the compression engine.
	typedef struct packed {
		word_t word;
		logic  blk_end;
		logic  msg_end;
	} qword_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
endpackage
`default_nettype wire

>>> sv/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Hashes a byte stream and returns the eight digest words of each message.
// ----------------------------------------------------------------------------
// Usage: the input channel (valid/ready) takes one transaction per byte,
// with byte_valid marking a real byte and last closing the message. The
// front end takes at most one byte per cycle and packs words into a
// four-entry queue. The compression engine takes one queued word per cycle
// while it loads, then runs 64 rounds (one per cycle) and a chain update.
// While the rounds run, the front end can take only 19 more bytes (four
// queued words and three bytes) before it stalls. After last, the front end
// feeds the padding and length one byte per cycle while the queue takes
// words; they fill the current block and may need one more. For an empty
// message that starts a block, the first digest word is valid after the
// remaining 63 padding and length bytes, the load of the last word, the 64
// rounds and the chain update. The engine then shows eight transactions on
// the output channel (digest_word, word_index 0..7, digest_last on word 7),
// one per cycle while ready is high. A stalled receiver holds the engine in
// its output state; the queue then fills and input stalls. Reset restores
// the initial hash and clears the length and positions.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             digest_last
);
	sha_pkg::qword_t f_data, e_data;
	logic f_valid, f_ready, e_valid, e_ready;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte), .byte_valid(byte_valid),
		.last(last), .valid(in_valid), .ready(in_ready),
		.wq_data(f_data), .wq_valid(f_valid), .wq_ready(f_ready)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_data(f_data), .in_valid(f_valid),
		.in_ready(f_ready), .out_data(e_data), .out_valid(e_valid), .out_ready(e_ready)
	);

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n), .wq_data(e_data), .wq_valid(e_valid),
		.wq_ready(e_ready), .digest_word(digest_word), .word_index(word_index),
		.digest_last(digest_last), .out_valid(out_valid), .out_ready(out_ready)
	);
endmodule
`default_nettype wire

>>> sv/sha_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs bytes into words, counts the length and generates the padding.
// ----------------------------------------------------------------------------
module sha_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    data_byte,
	input  wire logic          byte_valid,
	input  wire logic          last,
	input  wire logic          valid,
	output logic               ready,
	output sha_pkg::qword_t    wq_data,
	output logic               wq_valid,
	input  wire logic          wq_ready
);
	typedef enum logic [2:0] {
		ST_DATA = 3'b001,
		ST_PAD  = 3'b010,
		ST_LEN  = 3'b100
	} fst_t;

	fst_t           st_q;
	logic [5:0]     pos_q;
	logic [63:0]    bits_q;
	logic [23:0]    part_q;
	logic           pend_q;
	logic [7:0]     cur_byte;
	logic [7:0]     byte_now;
	logic           emit;
	logic           take;
	logic           step;
	sha_pkg::word_t full_word;

	// A word leaves whenever its fourth byte is placed; the queue must take it.
	assign take = valid && ready;

	always_comb begin
		case (st_q)
			ST_DATA: cur_byte = byte_valid ? data_byte : sha_pkg::PadByte;
			ST_LEN:  cur_byte = bits_q[{3'd7 - pos_q[2:0], 3'd0} +: 8];
			default: cur_byte = 8'h00;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		case (st_q)
			ST_DATA: emit = take && (byte_valid || last);
			ST_PAD:  emit = 1'b1;
			ST_LEN:  emit = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	// In the data state a valid-with-last byte is followed by the 0x80 byte, with ready low.
	assign ready = (st_q == ST_DATA) && !pend_q && (pos_q[1:0] != 2'd3 || wq_ready);

	assign byte_now = pend_q ? sha_pkg::PadByte : cur_byte;
	assign full_word = {part_q, byte_now};
	assign wq_data = {full_word, pos_q == 6'd63, (st_q == ST_LEN) && (pos_q == 6'd63)};

	always_comb begin
		step = 1'b0;
		case (st_q)
			ST_DATA: step = pend_q ? (pos_q[1:0] != 2'd3 || wq_ready)
				: emit;
			default: step = (pos_q[1:0] != 2'd3 || wq_ready);
		endcase
	end
	assign wq_valid = step && (pos_q[1:0] == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_DATA;
			pos_q  <= '0;
			bits_q <= '0;
			pend_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_q + 6'd1;
			case (st_q)
				ST_DATA: begin
					if (pend_q || !byte_valid) begin
						pend_q <= 1'b0;
						st_q <= (pos_q == 6'd55) ? ST_LEN : ST_PAD;
					end else begin
						bits_q <= bits_q + 64'd8;
						if (last) pend_q <= 1'b1;
					end
				end
				ST_PAD: if (pos_q == 6'd55) st_q <= ST_LEN;
				ST_LEN: if (pos_q == 6'd63) begin
					st_q <= ST_DATA;
					bits_q <= '0;
				end
				default: st_q <= ST_DATA;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			case (pos_q[1:0])
				2'd0: part_q[23:16] <= byte_now;
				2'd1: part_q[15:8]  <= byte_now;
				2'd2: part_q[7:0]   <= byte_now;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/sha_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_core_defines.svh"
module sha_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  sha_pkg::qword_t in_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	output sha_pkg::qword_t out_data,
	output logic            out_valid,
	input  wire logic       out_ready
);
	sha_pkg::qword_t mem_q [sha_pkg::QDepth];
	logic [sha_pkg::QPtrW-1:0] wp_q, rp_q;
	logic [sha_pkg::QPtrW:0]   cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 3'(sha_pkg::QDepth));
	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	`SHA_ASSERT_IMP(a_q_bound, 1'b1, cnt_q <= 3'(sha_pkg::QDepth), "queue count overflow")
	`SHA_ASSERT_NEXT(a_q_push, push && !pop, cnt_q == $past(cnt_q) + 3'd1, "push lost")
	`SHA_ASSERT_NEXT(a_q_pop, pop && !push, cnt_q == $past(cnt_q) - 3'd1, "pop lost")
endmodule
`default_nettype wire

>>> sv/sha_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Loads 16 words, runs 64 rounds, updates the chain and emits digests.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_core_defines.svh"
module sha_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  sha_pkg::qword_t      wq_data,
	input  wire logic            wq_valid,
	output logic                 wq_ready,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 digest_last,
	output logic                 out_valid,
	input  wire logic            out_ready
);
	typedef enum logic [3:0] {
		E_LOAD = 4'b0001,
		E_RUN  = 4'b0010,
		E_ADD  = 4'b0100,
		E_OUT  = 4'b1000
	} est_t;

	est_t st_q;
	sha_pkg::word_t w_q [16];
	sha_pkg::word_t h_q [8];
	sha_pkg::word_t v_q [8];
	logic [5:0] rnd_q;
	logic [3:0] wcnt_q;
	logic       fin_q;
	logic [2:0] oi_q;
	sha_pkg::word_t w_new, t1, t2;

	assign wq_ready = (st_q == E_LOAD);
	assign w_new = sha_pkg::sig1(w_q[14]) + w_q[9] + sha_pkg::sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha_pkg::RoundK[rnd_q] + w_q[0];
	assign t2 = sha_pkg::bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign out_valid = (st_q == E_OUT);
	assign digest_word = h_q[oi_q];
	assign word_index = oi_q;
	assign digest_last = (oi_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_LOAD;
			rnd_q <= '0;
			wcnt_q <= '0;
			fin_q <= 1'b0;
			oi_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::InitHash[i];
				v_q[i] <= '0;
			end
		end else begin
			case (st_q)
				E_LOAD: if (wq_valid) begin
					wcnt_q <= wcnt_q + 4'd1;
					if (wq_data.blk_end) begin
						fin_q <= wq_data.msg_end;
						st_q <= E_RUN;
						rnd_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				E_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					if (rnd_q == 6'd63) st_q <= E_ADD;
				end
				E_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					st_q <= fin_q ? E_OUT : E_LOAD;
					oi_q <= '0;
				end
				E_OUT: if (out_ready) begin
					oi_q <= oi_q + 3'd1;
					if (oi_q == 3'd7) begin
						st_q <= E_LOAD;
						for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
					end
				end
				default: st_q <= E_LOAD;
			endcase
		end
	end

	// The window shifts: loading appends at the top, each round retires one word.
	always_ff @(posedge clk) begin
		if (st_q == E_LOAD && wq_valid) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wq_data.word;
		end else if (st_q == E_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
	end

	`SHA_ASSERT_IMP(a_e_blk, st_q == E_LOAD && wq_valid && wq_data.blk_end,
		wcnt_q == 4'd15, "block end not on sixteenth word")
	`SHA_ASSERT_NEXT(a_e_out, st_q == E_OUT && out_ready && oi_q == 3'd7,
		st_q == E_LOAD, "digest did not finish")
	`SHA_ASSERT_IMP(a_e_msg, st_q == E_LOAD && wq_valid && wq_data.msg_end,
		wq_data.blk_end, "message end inside a block")
endmodule
`default_nettype wire
